// ===== hdl/binary_gcd_64_unit_macros.svh =====
// Assertion macros for the binary gcd unit.
`ifndef BINARY_GCD_64_UNIT_MACROS_SVH
`define BINARY_GCD_64_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BGCD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bgcd assertion failed");

// Next-cycle implication, disabled during reset.
`define BGCD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bgcd assertion failed");

`endif

// ===== hdl/bgcd_pkg.sv =====
// Shared types and constants for the binary gcd unit.
package bgcd_pkg;

  localparam int PORT_W = 64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ZCHK,
    S_COMMON,
    S_STRIP,
    S_SUB,
    S_FINISH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic zfix;
    logic halve_both;
    logic strip;
    logic sub;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic u_zero;
    logic v_zero;
    logic u_odd;
    logic v_odd;
    logic eq;
  } status_t;

endpackage

// ===== hdl/bgcd_dp.sv =====
// Datapath of the binary gcd unit: operand registers, shift count, subtractor.
`include "binary_gcd_64_unit_macros.svh"

module bgcd_dp #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  bgcd_pkg::cmd_t          cmd,
  input  logic                    op,
  input  logic [DATA_WIDTH-1:0]   a_in,
  input  logic [DATA_WIDTH-1:0]   b_in,
  output bgcd_pkg::status_t       status,
  output logic [DATA_WIDTH-1:0]   result
);

  localparam int K_W = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] u;
  logic [DATA_WIDTH-1:0] v;
  logic [K_W-1:0]        k;
  logic [DATA_WIDTH-1:0] res;
  logic [DATA_WIDTH-1:0] a_mag;
  logic [DATA_WIDTH-1:0] b_mag;
  logic                  u_gt;
  logic [DATA_WIDTH-1:0] diff;

  always_comb begin
    a_mag = (op && a_in[DATA_WIDTH-1]) ? (~a_in + 1'b1) : a_in;
    b_mag = (op && b_in[DATA_WIDTH-1]) ? (~b_in + 1'b1) : b_in;
    u_gt  = u > v;
    diff  = u_gt ? (u - v) : (v - u);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      u <= a_mag;
      v <= b_mag;
      k <= '0;
    end else if (cmd.zfix) begin
      u <= u | v;
      v <= '0;
    end else if (cmd.halve_both) begin
      u <= u >> 1;
      v <= v >> 1;
      k <= k + 1'b1;
    end else if (cmd.strip) begin
      if (!u[0]) begin
        u <= u >> 1;
      end
      if (!v[0]) begin
        v <= v >> 1;
      end
    end else if (cmd.sub) begin
      // difference of two odd values is even: drop one zero right away
      if (u_gt) begin
        u <= v;
      end
      v <= diff >> 1;
    end
    if (cmd.finish) begin
      res <= u << k;
    end
  end

  always_comb begin
    status.u_zero = (u == '0);
    status.v_zero = (v == '0);
    status.u_odd  = u[0];
    status.v_odd  = v[0];
    status.eq     = (u == v);
  end

  assign result = res;

  `BGCD_ASSERT_NXT(a_sub_nonzero, clk, rst, cmd.sub && !status.eq, v != '0)
  `BGCD_ASSERT_NXT(a_strip_odd_hold, clk, rst, cmd.strip && u[0], u == $past(u))
  `BGCD_ASSERT_IMP(a_sub_both_odd, clk, rst, cmd.sub, u[0] && v[0])

endmodule

// ===== hdl/bgcd_ctrl.sv =====
// Controller state machine of the binary gcd unit.
`include "binary_gcd_64_unit_macros.svh"

module bgcd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  bgcd_pkg::status_t   status,
  output bgcd_pkg::cmd_t      cmd,
  output logic                busy,
  output logic                done
);

  bgcd_pkg::state_t state;
  bgcd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bgcd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      bgcd_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = bgcd_pkg::S_ZCHK;
        end
      end
      bgcd_pkg::S_ZCHK: begin
        if (status.u_zero || status.v_zero) begin
          cmd.zfix   = 1'b1;
          state_next = bgcd_pkg::S_FINISH;
        end else begin
          state_next = bgcd_pkg::S_COMMON;
        end
      end
      bgcd_pkg::S_COMMON: begin
        if (!status.u_odd && !status.v_odd) begin
          cmd.halve_both = 1'b1;
        end else begin
          state_next = bgcd_pkg::S_STRIP;
        end
      end
      bgcd_pkg::S_STRIP: begin
        if (status.u_odd && status.v_odd) begin
          state_next = bgcd_pkg::S_SUB;
        end else begin
          cmd.strip = 1'b1;
        end
      end
      bgcd_pkg::S_SUB: begin
        if (status.eq) begin
          state_next = bgcd_pkg::S_FINISH;
        end else begin
          cmd.sub    = 1'b1;
          state_next = bgcd_pkg::S_STRIP;
        end
      end
      bgcd_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = bgcd_pkg::S_DONE;
      end
      bgcd_pkg::S_DONE: begin
        done       = 1'b1;
        state_next = bgcd_pkg::S_IDLE;
      end
      default: begin
        state_next = bgcd_pkg::S_IDLE;
      end
    endcase
  end

  `BGCD_ASSERT_IMP(a_cmd_onehot, clk, rst, 1'b1, $onehot0(cmd))
  `BGCD_ASSERT_NXT(a_accept_zchk, clk, rst, start && !busy, state == bgcd_pkg::S_ZCHK)
  `BGCD_ASSERT_IMP(a_done_after_finish, clk, rst, done, $past(state) == bgcd_pkg::S_FINISH)

endmodule

// ===== hdl/binary_gcd_64_unit.sv =====
// Top level of the binary gcd unit: controller plus datapath.
// A subtract step and its odd check together remove at least one bit.
// One operation at a time; a new start is taken the cycle after done.
// The result is valid on gcd_value for the single done cycle; no backpressure.
// Reset (rst, synchronous, active high) returns the controller to idle.
module binary_gcd_64_unit #(
  parameter int DATA_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [63:0] operand_a,
  input  logic [63:0] operand_b,
  output logic        done,
  output logic [63:0] gcd_value
);

  localparam int PW = bgcd_pkg::PORT_W;

  bgcd_pkg::cmd_t        cmd;
  bgcd_pkg::status_t     status;
  logic [DATA_WIDTH-1:0] result;

  bgcd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  bgcd_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .op     (op),
    .a_in   (operand_a[DATA_WIDTH-1:0]),
    .b_in   (operand_b[DATA_WIDTH-1:0]),
    .status (status),
    .result (result)
  );

  assign gcd_value = PW'(result);

endmodule
